### hdl/rngb_pkg.sv
package rngb_pkg;

    localparam int COORD_W    = 16;
    localparam int IN_COORDS  = 4;
    localparam int IDX_OUT_W  = 6;
    localparam int EDGE_W     = 11;
    localparam int DEG_W      = 6;
    localparam int RADIUS_W   = 16;
    localparam int DIMS_W     = 3;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DIMENSIONS = 1'b1;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = '0;
    localparam logic [DIMS_W-1:0]   DIMS_RESET   = 3'd2;

    localparam logic [DEG_W-1:0]  DEG_MAX  = '1;
    localparam logic [EDGE_W-1:0] EDGE_MAX = '1;

    typedef struct packed {
        logic                       first_point;
        logic signed [COORD_W-1:0]  coord_x;
        logic signed [COORD_W-1:0]  coord_y;
        logic signed [COORD_W-1:0]  coord_z;
        logic signed [COORD_W-1:0]  coord_w;
    } point_t;

    typedef struct packed {
        logic [IDX_OUT_W-1:0] point_index;
        logic [IDX_OUT_W-1:0] neighbor_index;
        logic                 edge_found;
        logic [EDGE_W-1:0]    edge_total;
        logic [DEG_W-1:0]     peak_degree;
        logic                 overflow;
        logic                 last;
    } result_t;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_THR  = 8'b0000_0010,
        ST_LDT  = 8'b0000_0100,
        ST_RD   = 8'b0000_1000,
        ST_MUL  = 8'b0001_0000,
        ST_ACC  = 8'b0010_0000,
        ST_CMP  = 8'b0100_0000,
        ST_FIN  = 8'b1000_0000
    } state_t;

endpackage

### hdl/rngb_square.sv
module rngb_square #(
    parameter int OP_W = 16
) (
    input  logic                  clk,
    input  logic signed [OP_W:0]  operand,
    output logic [2*OP_W-1:0]     product
);

    logic [OP_W:0]   mag_full;
    logic [OP_W-1:0] mag;
    logic [2*OP_W-1:0] product_reg;

    // operand never reaches the most negative value, so the magnitude fits
    assign mag_full = operand[OP_W] ? (OP_W+1)'(-operand) : (OP_W+1)'(operand);
    assign mag      = mag_full[OP_W-1:0];

    always_ff @(posedge clk)
    begin
        product_reg <= (2*OP_W)'(mag) * (2*OP_W)'(mag);
    end

    assign product = product_reg;

endmodule

### hdl/radius_neighbor_graph_builder_top.sv
// Radius neighbour graph builder. Each accepted point gets the next free index and is
// compared with every stored earlier point in ascending index order; every pair whose
// squared distance over the active coordinates is strictly below radius squared yields
// one result (earlier index, new index, running edge count and largest degree), with
// last set on the final result of the point. A point with no neighbour yields a single
// result with edge_found low, and a point arriving at a full store yields one overflow
// result and is dropped. first_point clears the graph before the point is handled.
// All squaring runs through one registered multiplier under a small sequencer, one
// coordinate at a time, so a point waits for every stored earlier point to be scanned,
// and longer while the output side stalls; a point with index zero or a dropped point
// skips the scan. point_stall is high from the transfer until the point is finished.
// The point and degree stores are single-port memories with registered reads.
module radius_neighbor_graph_builder_top #(
    parameter int MAX_POINTS = 64,
    parameter int MAX_DIM    = 4,
    parameter int COORD_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [rngb_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [rngb_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  point_valid,
    output logic                                  point_stall,
    input  rngb_pkg::point_t                      point,
    output logic                                  result_valid,
    input  logic                                  result_stall,
    output rngb_pkg::result_t                     result
);

    localparam int NDIM   = (MAX_DIM < rngb_pkg::IN_COORDS) ? MAX_DIM : rngb_pkg::IN_COORDS;
    localparam int IDX_W  = $clog2(MAX_POINTS);
    localparam int CNT_W  = IDX_W + 1;
    localparam int D_W    = (NDIM > 2) ? 2 : 1;
    localparam int OP_W   = (COORD_BITS > rngb_pkg::RADIUS_W) ? COORD_BITS : rngb_pkg::RADIUS_W;
    localparam int PROD_W = 2 * OP_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int PT_W   = NDIM * COORD_BITS;
    localparam int C_HI   = (1 << (COORD_BITS - 1)) - 1;
    localparam int C_LO   = -C_HI - 1;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_POINTS);

    // control state
    rngb_pkg::state_t                 state_reg, state_next;
    logic [rngb_pkg::RADIUS_W-1:0]    radius_reg;
    logic [rngb_pkg::DIMS_W-1:0]      dims_reg;
    logic [CNT_W-1:0]                 count_reg, count_next;
    logic [rngb_pkg::EDGE_W-1:0]      edge_cnt_reg, edge_cnt_next;
    logic [rngb_pkg::DEG_W-1:0]       largest_reg, largest_next;
    logic [IDX_W-1:0]                 me_reg, me_next;
    logic [IDX_W-1:0]                 j_reg, j_next;
    logic [D_W-1:0]                   d_reg, d_next;
    logic [D_W-1:0]                   nd_last_reg, nd_last_next;
    logic [rngb_pkg::DEG_W-1:0]       me_deg_reg, me_deg_next;
    logic                             ovf_reg, ovf_next;
    logic                             pend_valid_reg, pend_valid_next;
    logic                             out_valid_reg, out_valid_next;
    logic [MAX_POINTS-1:0]            deg_vld_reg;

    // datapath
    logic signed [COORD_BITS-1:0]     c_reg [NDIM];
    logic [SUM_W-1:0]                 thr_reg;
    logic [SUM_W-1:0]                 sum_reg;
    rngb_pkg::result_t                pend_reg;
    rngb_pkg::result_t                out_reg;
    logic [PT_W-1:0]                  pt_rd_reg;
    logic [rngb_pkg::DEG_W-1:0]       deg_rd_reg;
    logic                             deg_ok_reg;

    logic [PT_W-1:0]                  pt_mem  [MAX_POINTS];
    logic [rngb_pkg::DEG_W-1:0]       deg_mem [MAX_POINTS];

    logic signed [rngb_pkg::COORD_W-1:0] in_coord [rngb_pkg::IN_COORDS];
    logic [rngb_pkg::DIMS_W-1:0]      act_dims;
    logic                             accept;
    logic                             out_xfer;
    logic                             can_load;
    logic                             edge_hit;
    logic                             cmp_commit;
    logic                             cmp_advance;
    logic                             fin_go;
    logic                             out_load;
    logic [CNT_W-1:0]                 count_base;
    logic [rngb_pkg::DEG_W-1:0]       deg_j_cur;
    logic [rngb_pkg::DEG_W-1:0]       deg_j_new;
    logic [rngb_pkg::DEG_W-1:0]       deg_me_new;
    logic [rngb_pkg::DEG_W-1:0]       largest_bump;
    logic [rngb_pkg::EDGE_W-1:0]      edge_cnt_bump;
    logic                             deg_we;
    logic [IDX_W-1:0]                 deg_wr_addr;
    logic [rngb_pkg::DEG_W-1:0]       deg_wr_data;
    logic [PT_W-1:0]                  pt_wr_data;
    logic signed [COORD_BITS-1:0]     stored_coord;
    logic signed [COORD_BITS:0]       diff;
    logic signed [OP_W:0]             sq_op;
    logic [PROD_W-1:0]                prod;
    rngb_pkg::result_t                new_edge;
    rngb_pkg::result_t                final_res;
    rngb_pkg::result_t                out_load_data;

    function automatic logic signed [COORD_BITS-1:0] sat_coord(
        input logic signed [rngb_pkg::COORD_W-1:0] v
    );
        logic signed [31:0] w;
        w = 32'(v);
        if (w > C_HI)
        begin
            w = C_HI;
        end
        else if (w < C_LO)
        begin
            w = C_LO;
        end
        return w[COORD_BITS-1:0];
    endfunction

    assign in_coord[0] = point.coord_x;
    assign in_coord[1] = point.coord_y;
    assign in_coord[2] = point.coord_z;
    assign in_coord[3] = point.coord_w;

    assign point_stall  = (state_reg != rngb_pkg::ST_IDLE);
    assign accept       = point_valid && (state_reg == rngb_pkg::ST_IDLE);
    assign out_xfer     = out_valid_reg && !result_stall;
    assign can_load     = !out_valid_reg || !result_stall;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_comb
    begin
        if (dims_reg == '0)
        begin
            act_dims = rngb_pkg::DIMS_W'(1);
        end
        else if (dims_reg > rngb_pkg::DIMS_W'(NDIM))
        begin
            act_dims = rngb_pkg::DIMS_W'(NDIM);
        end
        else
        begin
            act_dims = dims_reg;
        end
    end

    assign count_base = point.first_point ? '0 : count_reg;

    // shared squarer: radius once per point, then one coordinate difference at a time
    assign stored_coord = pt_rd_reg[d_reg*COORD_BITS +: COORD_BITS];
    assign diff = (COORD_BITS+1)'(c_reg[d_reg]) - (COORD_BITS+1)'(stored_coord);
    assign sq_op = (state_reg == rngb_pkg::ST_THR)
                 ? (OP_W+1)'($signed({1'b0, radius_reg}))
                 : (OP_W+1)'(diff);

    rngb_square #(
        .OP_W (OP_W)
    ) u_square (
        .clk     (clk),
        .operand (sq_op),
        .product (prod)
    );

    // degree update and running totals for one edge
    assign edge_hit   = sum_reg < thr_reg;
    assign deg_j_cur  = deg_ok_reg ? deg_rd_reg : '0;
    assign deg_j_new  = (deg_j_cur < rngb_pkg::DEG_MAX) ? deg_j_cur + 1'b1 : deg_j_cur;
    assign deg_me_new = (me_deg_reg < rngb_pkg::DEG_MAX) ? me_deg_reg + 1'b1 : me_deg_reg;

    always_comb
    begin
        largest_bump = largest_reg;
        if (deg_j_new > largest_bump)
        begin
            largest_bump = deg_j_new;
        end
        if (deg_me_new > largest_bump)
        begin
            largest_bump = deg_me_new;
        end
    end

    assign edge_cnt_bump = (edge_cnt_reg < rngb_pkg::EDGE_MAX) ? edge_cnt_reg + 1'b1
                                                               : edge_cnt_reg;

    // a new edge may only displace the held one once the output register is free
    assign cmp_commit  = (state_reg == rngb_pkg::ST_CMP) && edge_hit
                       && (!pend_valid_reg || can_load);
    assign cmp_advance = (state_reg == rngb_pkg::ST_CMP)
                       && (!edge_hit || !pend_valid_reg || can_load);
    assign fin_go      = (state_reg == rngb_pkg::ST_FIN) && can_load;
    assign out_load    = (cmp_commit && pend_valid_reg) || fin_go;

    always_comb
    begin
        new_edge                = '0;
        new_edge.point_index    = rngb_pkg::IDX_OUT_W'(me_reg);
        new_edge.neighbor_index = rngb_pkg::IDX_OUT_W'(j_reg);
        new_edge.edge_found     = 1'b1;
        new_edge.edge_total     = edge_cnt_bump;
        new_edge.peak_degree    = largest_bump;

        final_res = '0;
        if (ovf_reg)
        begin
            final_res.edge_total  = edge_cnt_reg;
            final_res.peak_degree = largest_reg;
            final_res.overflow    = 1'b1;
        end
        else if (pend_valid_reg)
        begin
            final_res = pend_reg;
        end
        else
        begin
            final_res.point_index = rngb_pkg::IDX_OUT_W'(me_reg);
            final_res.edge_total  = edge_cnt_reg;
            final_res.peak_degree = largest_reg;
        end
        final_res.last = 1'b1;

        out_load_data = fin_go ? final_res : pend_reg;
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        edge_cnt_next   = edge_cnt_reg;
        largest_next    = largest_reg;
        me_next         = me_reg;
        j_next          = j_reg;
        d_next          = d_reg;
        nd_last_next    = nd_last_reg;
        me_deg_next     = me_deg_reg;
        ovf_next        = ovf_reg;
        pend_valid_next = pend_valid_reg;

        case (state_reg)
            rngb_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (point.first_point)
                    begin
                        count_next    = '0;
                        edge_cnt_next = '0;
                        largest_next  = '0;
                    end
                    me_next      = count_base[IDX_W-1:0];
                    j_next       = '0;
                    me_deg_next  = '0;
                    nd_last_next = D_W'(act_dims - 1'b1);
                    if (count_base == FULL_COUNT)
                    begin
                        ovf_next   = 1'b1;
                        state_next = rngb_pkg::ST_FIN;
                    end
                    else
                    begin
                        ovf_next = 1'b0;
                        if (count_base == '0)
                        begin
                            state_next = rngb_pkg::ST_FIN;
                        end
                        else
                        begin
                            state_next = rngb_pkg::ST_THR;
                        end
                    end
                end
            end
            rngb_pkg::ST_THR:
            begin
                state_next = rngb_pkg::ST_LDT;
            end
            rngb_pkg::ST_LDT:
            begin
                state_next = rngb_pkg::ST_RD;
            end
            rngb_pkg::ST_RD:
            begin
                d_next     = '0;
                state_next = rngb_pkg::ST_MUL;
            end
            rngb_pkg::ST_MUL:
            begin
                state_next = rngb_pkg::ST_ACC;
            end
            rngb_pkg::ST_ACC:
            begin
                if (d_reg == nd_last_reg)
                begin
                    state_next = rngb_pkg::ST_CMP;
                end
                else
                begin
                    d_next     = d_reg + 1'b1;
                    state_next = rngb_pkg::ST_MUL;
                end
            end
            rngb_pkg::ST_CMP:
            begin
                if (cmp_commit)
                begin
                    me_deg_next     = deg_me_new;
                    largest_next    = largest_bump;
                    edge_cnt_next   = edge_cnt_bump;
                    pend_valid_next = 1'b1;
                end
                if (cmp_advance)
                begin
                    j_next = j_reg + 1'b1;
                    if (j_reg + 1'b1 == me_reg)
                    begin
                        state_next = rngb_pkg::ST_FIN;
                    end
                    else
                    begin
                        state_next = rngb_pkg::ST_RD;
                    end
                end
            end
            rngb_pkg::ST_FIN:
            begin
                if (fin_go)
                begin
                    pend_valid_next = 1'b0;
                    if (!ovf_reg)
                    begin
                        count_next = CNT_W'(me_reg) + 1'b1;
                    end
                    state_next = rngb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rngb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_xfer)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= rngb_pkg::ST_IDLE;
            radius_reg     <= rngb_pkg::RADIUS_RESET;
            dims_reg       <= rngb_pkg::DIMS_RESET;
            count_reg      <= '0;
            edge_cnt_reg   <= '0;
            largest_reg    <= '0;
            me_reg         <= '0;
            j_reg          <= '0;
            d_reg          <= '0;
            nd_last_reg    <= '0;
            me_deg_reg     <= '0;
            ovf_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            edge_cnt_reg   <= edge_cnt_next;
            largest_reg    <= largest_next;
            me_reg         <= me_next;
            j_reg          <= j_next;
            d_reg          <= d_next;
            nd_last_reg    <= nd_last_next;
            me_deg_reg     <= me_deg_next;
            ovf_reg        <= ovf_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    rngb_pkg::REG_RADIUS:
                    begin
                        radius_reg <= cfg_data;
                    end
                    rngb_pkg::REG_DIMENSIONS:
                    begin
                        dims_reg <= cfg_data[rngb_pkg::DIMS_W-1:0];
                    end
                    default:
                    begin
                        radius_reg <= radius_reg;
                    end
                endcase
            end
        end
    end

    // degree valid bits: an entry not yet written since the last clear reads as zero
    assign deg_we      = cmp_commit || (fin_go && !ovf_reg);
    assign deg_wr_addr = fin_go ? me_reg : j_reg;
    assign deg_wr_data = fin_go ? me_deg_reg : deg_j_new;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deg_vld_reg <= '0;
        end
        else if (accept && point.first_point)
        begin
            deg_vld_reg <= '0;
        end
        else if (deg_we)
        begin
            deg_vld_reg[deg_wr_addr] <= 1'b1;
        end
    end

    always_comb
    begin
        for (int k = 0; k < NDIM; k++)
        begin
            pt_wr_data[k*COORD_BITS +: COORD_BITS] = c_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (deg_we)
        begin
            deg_mem[deg_wr_addr] <= deg_wr_data;
        end
        if (state_reg == rngb_pkg::ST_RD)
        begin
            deg_rd_reg <= deg_mem[j_reg];
            deg_ok_reg <= deg_vld_reg[j_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_go && !ovf_reg)
        begin
            pt_mem[me_reg] <= pt_wr_data;
        end
        if (state_reg == rngb_pkg::ST_RD)
        begin
            pt_rd_reg <= pt_mem[j_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int k = 0; k < NDIM; k++)
            begin
                // unused coordinates are stored as zero
                if (k < int'(act_dims))
                begin
                    c_reg[k] <= sat_coord(in_coord[k]);
                end
                else
                begin
                    c_reg[k] <= '0;
                end
            end
        end
        if (state_reg == rngb_pkg::ST_LDT)
        begin
            thr_reg <= SUM_W'(prod);
        end
        if (state_reg == rngb_pkg::ST_RD)
        begin
            sum_reg <= '0;
        end
        else if (state_reg == rngb_pkg::ST_ACC)
        begin
            sum_reg <= sum_reg + SUM_W'(prod);
        end
        if (cmp_commit)
        begin
            pend_reg <= new_edge;
        end
        if (out_load)
        begin
            out_reg <= out_load_data;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("point count above capacity");

    a_pend_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (state_reg == rngb_pkg::ST_RD || state_reg == rngb_pkg::ST_MUL
                            || state_reg == rngb_pkg::ST_ACC || state_reg == rngb_pkg::ST_CMP
                            || state_reg == rngb_pkg::ST_FIN))
        else $error("held edge result outside a point");

    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rngb_pkg::ST_RD) |-> (j_reg < me_reg))
        else $error("scan index beyond new point");

    a_mid_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rngb_pkg::ST_CMP && out_load) |=> !result.last)
        else $error("edge released mid-scan marked last");

    a_edges_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != rngb_pkg::ST_IDLE) |=> (edge_cnt_reg >= $past(edge_cnt_reg)))
        else $error("edge count fell during a point");
`endif

endmodule

### tb/radius_neighbor_graph_builder_top_tb.sv
module radius_neighbor_graph_builder_top_tb;

    localparam int CAPACITY   = 64;
    localparam int NUM_COORDS = 4;

    logic                            clk          = 1'b0;
    logic                            rst_n        = 1'b0;
    logic                            cfg_we       = 1'b0;
    logic [rngb_pkg::CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [rngb_pkg::CFG_DATA_W-1:0] cfg_data     = '0;
    logic                            point_valid  = 1'b0;
    logic                            point_stall;
    rngb_pkg::point_t                point        = '0;
    logic                            result_valid;
    logic                            result_stall = 1'b0;
    rngb_pkg::result_t               result;

    radius_neighbor_graph_builder_top #(
        .MAX_POINTS(CAPACITY),
        .MAX_DIM   (NUM_COORDS),
        .COORD_BITS(rngb_pkg::COORD_W)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .point_valid (point_valid),
        .point_stall (point_stall),
        .point       (point),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result      (result)
    );

    // register copies and graph state as the block should hold them
    logic [rngb_pkg::RADIUS_W-1:0]       radius_reg = rngb_pkg::RADIUS_RESET;
    logic [rngb_pkg::DIMS_W-1:0]         dims_reg   = rngb_pkg::DIMS_RESET;
    logic signed [rngb_pkg::COORD_W-1:0] point_mem [CAPACITY][NUM_COORDS];
    logic [rngb_pkg::DEG_W-1:0]          degree_mem [CAPACITY];
    int unsigned                         stored_points;
    int unsigned                         edge_count_q;
    int unsigned                         peak_deg;

    rngb_pkg::point_t  points_to_send [$];
    rngb_pkg::result_t pending_results [$];
    rngb_pkg::result_t oldest_expected;

    int send_idle_pct   = 0;
    int stall_pct       = 0;
    int hold_left       = 0;
    int failures        = 0;
    int points_accepted = 0;
    int results_checked = 0;
    int overflow_seen   = 0;
    int settings_used   = 0;
    logic [rngb_pkg::DEG_W-1:0] top_degree_seen = '0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic void clear_graph();
        for (int i = 0; i < CAPACITY; i++)
        begin
            degree_mem[i] = '0;
            for (int k = 0; k < NUM_COORDS; k++)
                point_mem[i][k] = '0;
        end
        stored_points = 0;
        edge_count_q  = 0;
        peak_deg      = 0;
    endfunction

    function automatic void bump_degree(int i);
        if (degree_mem[i] < rngb_pkg::DEG_MAX)
            degree_mem[i] = degree_mem[i] + 1'b1;
        if (degree_mem[i] > peak_deg)
            peak_deg = degree_mem[i];
    endfunction

    // joins a new point to every stored point inside the radius, queues its results
    function automatic void place_point(rngb_pkg::point_t p);
        logic signed [rngb_pkg::COORD_W-1:0] c [NUM_COORDS];
        longint  thr;
        longint  sq_sum;
        longint  diff;
        int      nd;
        int      me;
        int      hits;
        rngb_pkg::result_t r;

        if (p.first_point)
            clear_graph();
        r              = '0;
        r.edge_total   = rngb_pkg::EDGE_W'(edge_count_q);
        r.peak_degree  = rngb_pkg::DEG_W'(peak_deg);
        r.last         = 1'b1;
        if (stored_points >= CAPACITY)
        begin
            r.overflow = 1'b1;
            pending_results.push_back(r);
            return;
        end

        nd = (dims_reg == 0) ? 1 : ((dims_reg > NUM_COORDS) ? NUM_COORDS : int'(dims_reg));
        c[0] = p.coord_x;
        c[1] = p.coord_y;
        c[2] = p.coord_z;
        c[3] = p.coord_w;
        for (int k = nd; k < NUM_COORDS; k++)
            c[k] = '0;

        me   = stored_points;
        hits = 0;
        thr  = longint'(radius_reg) * longint'(radius_reg);
        for (int j = 0; j < me; j++)
        begin
            sq_sum = 0;
            for (int d = 0; d < nd; d++)
            begin
                diff = longint'(c[d]) - longint'(point_mem[j][d]);
                sq_sum += diff * diff;
            end
            if (sq_sum < thr)
            begin
                bump_degree(j);
                bump_degree(me);
                if (edge_count_q < rngb_pkg::EDGE_MAX)
                    edge_count_q++;
                r.point_index    = rngb_pkg::IDX_OUT_W'(me);
                r.neighbor_index = rngb_pkg::IDX_OUT_W'(j);
                r.edge_found     = 1'b1;
                r.edge_total     = rngb_pkg::EDGE_W'(edge_count_q);
                r.peak_degree    = rngb_pkg::DEG_W'(peak_deg);
                r.overflow       = 1'b0;
                r.last           = 1'b0;
                pending_results.push_back(r);
                hits++;
            end
        end

        for (int k = 0; k < NUM_COORDS; k++)
            point_mem[me][k] = c[k];
        stored_points = me + 1;

        if (hits == 0)
        begin
            r             = '0;
            r.point_index = rngb_pkg::IDX_OUT_W'(me);
            r.edge_total  = rngb_pkg::EDGE_W'(edge_count_q);
            r.peak_degree = rngb_pkg::DEG_W'(peak_deg);
            r.last        = 1'b1;
            pending_results.push_back(r);
        end
        else
            pending_results[pending_results.size() - 1].last = 1'b1;
    endfunction

    function automatic string describe(rngb_pkg::result_t r);
        return $sformatf("pt %0d nb %0d found %0b total %0d deg %0d ovf %0b last %0b",
                         r.point_index, r.neighbor_index, r.edge_found, r.edge_total,
                         r.peak_degree, r.overflow, r.last);
    endfunction

    function automatic void note_failure(string what, string want_text,
                                         rngb_pkg::result_t got);
        failures++;
        if (failures <= 10)
            $display("%s at %0t: expected %s, got %s", what, $time, want_text, describe(got));
    endfunction

    function automatic rngb_pkg::point_t make_point(bit first, int x, int y, int z, int w);
        rngb_pkg::point_t p;
        p.first_point = first;
        p.coord_x     = rngb_pkg::COORD_W'(x);
        p.coord_y     = rngb_pkg::COORD_W'(y);
        p.coord_z     = rngb_pkg::COORD_W'(z);
        p.coord_w     = rngb_pkg::COORD_W'(w);
        return p;
    endfunction

    // point side: the presented point stays at the head of the queue until its transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (point_valid && !point_stall)
            begin
                place_point(points_to_send.pop_front());
                points_accepted++;
            end
            if (!point_valid || !point_stall)
            begin
                if (points_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    point_valid <= 1'b1;
                    point       <= points_to_send[0];
                end
                else
                    point_valid <= 1'b0;
            end
        end
    end

    // result side stall, with an optional long hold-off
    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        result_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            results_checked++;
            if (result.overflow)
                overflow_seen++;
            if (result.peak_degree > top_degree_seen)
                top_degree_seen = result.peak_degree;
            if (pending_results.size() == 0)
                note_failure("unexpected result", "none", result);
            else
            begin
                oldest_expected = pending_results.pop_front();
                if (result.point_index    !== oldest_expected.point_index    ||
                    result.neighbor_index !== oldest_expected.neighbor_index ||
                    result.edge_found     !== oldest_expected.edge_found     ||
                    result.edge_total     !== oldest_expected.edge_total     ||
                    result.peak_degree    !== oldest_expected.peak_degree    ||
                    result.overflow       !== oldest_expected.overflow       ||
                    result.last           !== oldest_expected.last)
                    note_failure("result mismatch", describe(oldest_expected), result);
            end
        end
    end

    task automatic wait_drained();
        while (points_to_send.size() != 0 || pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [rngb_pkg::CFG_IDX_W-1:0] index,
                             logic [rngb_pkg::CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (index == rngb_pkg::REG_RADIUS)
            radius_reg = value;
        else
            dims_reg = value[rngb_pkg::DIMS_W-1:0];
    endtask

    // clusters of points around a random centre, with the odd stray point mixed in
    task automatic run_phase(logic [rngb_pkg::RADIUS_W-1:0] rad,
                             logic [rngb_pkg::DIMS_W-1:0] dims, int idle,
                             int stall, int items, bit fill_store, bit hold_off);
        int     remaining;
        int     len;
        int     spread;
        int     v;
        int     centre [NUM_COORDS];
        int     coords [NUM_COORDS];
        bit     tight;
        rngb_pkg::point_t p;

        wait_drained();
        write_reg(rngb_pkg::REG_RADIUS, rad);
        // upper data bits are don't-care for the dimensions register
        write_reg(rngb_pkg::REG_DIMENSIONS, rngb_pkg::CFG_DATA_W'({$urandom, dims}));
        settings_used++;
        send_idle_pct = idle;
        stall_pct     = stall;

        remaining = items;
        while (remaining > 0)
        begin
            tight      = fill_store;
            fill_store = 1'b0;
            len        = tight ? CAPACITY + 6 : int'($urandom_range(30, 3));
            if (len > remaining)
                len = remaining;
            spread = tight ? 8000 : (int'(rad) * int'($urandom_range(4, 1))) / 2 + 1;
            if (spread > 12000)
                spread = 12000;
            for (int k = 0; k < NUM_COORDS; k++)
                centre[k] = int'($urandom_range(40000)) - 20000;
            for (int i = 0; i < len; i++)
            begin
                if (!tight && $urandom_range(19) == 0)
                    p = make_point(1'($urandom_range(1)), int'($urandom), int'($urandom),
                                   int'($urandom), int'($urandom));
                else
                begin
                    for (int k = 0; k < NUM_COORDS; k++)
                    begin
                        v = centre[k] + int'($urandom_range(2 * spread)) - spread;
                        if (v > 32767)
                            v = 32767;
                        if (v < -32768)
                            v = -32768;
                        coords[k] = v;
                    end
                    p = make_point(i == 0, coords[0], coords[1], coords[2], coords[3]);
                end
                points_to_send.push_back(p);
            end
            remaining -= len;
        end

        if (hold_off)
        begin
            @(negedge clk);
            hold_left = 2500;
        end
        wait_drained();
    endtask

    initial
    begin
        clear_graph();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // registers at reset values: zero radius never makes an edge
        points_to_send.push_back(make_point(1'b1, 0, 0, 0, 0));
        points_to_send.push_back(make_point(1'b0, 0, 0, 0, 0));
        wait_drained();

        // radius 256 in two dimensions, a distance of exactly the radius must not join
        write_reg(rngb_pkg::REG_RADIUS, 16'h0100);
        settings_used++;
        points_to_send.push_back(make_point(1'b1, 0, 0, 32767, -32768));
        points_to_send.push_back(make_point(1'b0, 16'h0100, 0, -32768, 32767));
        points_to_send.push_back(make_point(1'b0, 0, 16'h00FF, 12345, -1));
        points_to_send.push_back(make_point(1'b0, 16'h0080, 16'h0080, -1, 0));
        wait_drained();

        // widest radius, four coordinates at the ends of their range
        write_reg(rngb_pkg::REG_RADIUS, 16'hFFFF);
        write_reg(rngb_pkg::REG_DIMENSIONS, rngb_pkg::CFG_DATA_W'(4));
        settings_used++;
        points_to_send.push_back(make_point(1'b1, -32768, -32768, -32768, -32768));
        points_to_send.push_back(make_point(1'b0, 32767, 32767, 32767, 32767));
        points_to_send.push_back(make_point(1'b0, 32767, -32768, 32767, -32768));
        points_to_send.push_back(make_point(1'b0, 0, 0, 0, 0));
        wait_drained();

        // zero dimensions behaves as one
        write_reg(rngb_pkg::REG_DIMENSIONS,
                  {{(rngb_pkg::CFG_DATA_W - rngb_pkg::DIMS_W){1'b1}}, rngb_pkg::DIMS_W'(0)});
        settings_used++;
        points_to_send.push_back(make_point(1'b1, -32768, 1, 2, 3));
        points_to_send.push_back(make_point(1'b0, 32767, -7, 900, -900));
        points_to_send.push_back(make_point(1'b0, 32766, 32767, -32768, 5));
        wait_drained();

        run_phase(16'($urandom_range(16'h2000, 16'h0400)), 3'd3, 0, 0, 80, 1'b0, 1'b0);
        run_phase(16'hFFFF, 3'd7, 75, 0, 80, 1'b1, 1'b0);
        run_phase(16'd1, 3'd1, 0, 75, 70, 1'b0, 1'b0);
        run_phase(16'($urandom), 3'd0, 33, 33, 70, 1'b0, 1'b0);
        run_phase(16'($urandom_range(16'h3000, 16'h0100)), 3'd4, 0, 0, 80, 1'b0, 1'b1);
        run_phase(16'($urandom), 3'($urandom_range(6, 5)), 33, 33, 70, 1'b1, 1'b0);

        wait_drained();
        repeat (100) @(posedge clk);

        $display("covered %0d points and %0d results over %0d register settings",
                 points_accepted, results_checked, settings_used);
        $display("store overflows seen %0d, highest degree reported %0d, failures %0d",
                 overflow_seen, top_degree_seen, failures);
        if (failures == 0)
            $display("radius_neighbor_graph_builder_top_tb: PASS");
        else
            $display("radius_neighbor_graph_builder_top_tb: FAIL");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("timeout with %0d points queued and %0d results outstanding",
                 points_to_send.size(), pending_results.size());
        $display("radius_neighbor_graph_builder_top_tb: FAIL");
        $finish;
    end

endmodule

### radius_neighbor_graph_builder_top.f
hdl/rngb_pkg.sv
hdl/rngb_square.sv
hdl/radius_neighbor_graph_builder_top.sv
tb/radius_neighbor_graph_builder_top_tb.sv
